// ----- src/hsv_to_rgb_pack_defines.svh -----
// Assertion macros shared by the conversion pipeline.
`ifndef HSV_TO_RGB_PACK_DEFINES_SVH
`define HSV_TO_RGB_PACK_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HSVRGB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define HSVRGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/hsvrgb_pkg.sv -----
package hsvrgb_pkg;

   // Width of the pixel transactions
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 48;

   // Hue sector split: 960 = 64 * 15, so hue/960 = (hue >> 6) / 15
   localparam logic [10:0] RECIP15_MUL = 11'd1093;   // ceil(2^14 / 15)
   localparam logic [9:0]  SECTOR_SPAN = 10'd960;
   localparam logic [5:0]  RECIP6_MUL  = 6'd43;      // ceil(2^8 / 6)
   localparam logic [2:0]  SECTOR_NUM  = 3'd6;
   localparam logic [14:0] FRAC_MUL    = 15'd17480;  // 2^16 * 256 / 960 = 17476.3, rounded up to 17480

   // Channel scaling: x / 65280 = (x >> 8) / 255
   localparam logic [15:0] FULL_SCALE  = 16'd65280;
   localparam logic [15:0] RECIP255_MUL = 16'd32897; // ceil(2^23 / 255)

   // 60-degree hue sectors
   typedef enum logic [2:0] {
      SECT_RED     = 3'd0,
      SECT_YELLOW  = 3'd1,
      SECT_GREEN   = 3'd2,
      SECT_CYAN    = 3'd3,
      SECT_BLUE    = 3'd4,
      SECT_MAGENTA = 3'd5
   } hsvrgb_sector_type;

   // Stage load enables handed to a channel lane
   typedef struct packed {
      logic load_mul;
      logic load_div;
   } hsvrgb_adv_type;

endpackage

// ----- src/hsvrgb_lane.sv -----
module hsvrgb_lane (
   input  logic                       clock,
   input  hsvrgb_pkg::hsvrgb_adv_type adv,
   input  logic [7:0]                 bright,
   input  logic [15:0]                scale,
   output logic [7:0]                 chan
);
   import hsvrgb_pkg::*;

   logic [23:0] prod_in;
   logic [15:0] mul_ff;
   logic [31:0] quot_prod;
   logic [7:0]  chan_in;
   logic [7:0]  chan_ff;

   // Form value times scale, drop the factor 256 of the full scale
   assign prod_in = 24'(bright) * 24'(scale);

   // Divide by 255 through the reciprocal
   assign quot_prod = 32'(mul_ff) * 32'(RECIP255_MUL);
   assign chan_in   = quot_prod[30:23];

   always_ff @(posedge clock) begin
      if (adv.load_mul) begin
         mul_ff <= prod_in[23:8];
      end
      if (adv.load_div) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

// ----- src/hsv_to_rgb_pack.sv -----
// HSV to RGB pixel converter, seven register stages.
// An accepted request transaction passes stage registers 1 to 7 before rsp_tvalid.
// Throughput: one pixel per cycle while rsp_tready stays high; each stage holds one pixel and loads
// whenever it is empty or its successor takes its contents.
// Reset: synchronous, active high; clears all stage valid bits, no data cleared.
`include "hsv_to_rgb_pack_defines.svh"

module hsv_to_rgb_pack (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // hue_sixteenths [15:0], sat_level [23:16], bright_level [31:24]
   input  logic [hsvrgb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // red_out [7:0], green_out [15:8], blue_out [23:16], packed_color [47:24]
   output logic [hsvrgb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hsvrgb_pkg::*;

   localparam int unsigned NSTG = 7;

   logic [NSTG:1] vld_ff;
   logic [NSTG:1] vld_in;
   logic [NSTG:1] rdy;

   // Stage 1: coarse quotient of hue by 960
   logic [20:0] quo_prod;
   logic [6:0]  quo1_in, quo1_ff;
   logic [15:0] hue1_ff;
   logic [7:0]  sat1_ff, bri1_ff;

   // Stage 2: remainder within the sector, quotient by 6
   logic [16:0] quo_span;
   logic [16:0] rem_diff;
   logic [12:0] q6_prod;
   logic [9:0]  rem2_in, rem2_ff;
   logic [3:0]  q6_2_in, q6_2_ff;
   logic [6:0]  quo2_ff;
   logic [7:0]  sat2_ff, bri2_ff;

   // Stage 3: sector number and 8-bit fraction
   logic [6:0]        sect_diff;
   logic [24:0]       frac_prod;
   hsvrgb_sector_type sect3_in, sect3_ff;
   logic [7:0]        frac3_in, frac3_ff;
   logic [7:0]        sat3_ff, bri3_ff;

   // Stage 4: scale factors for p, q and t
   logic [15:0]       subq;
   logic [16:0]       subt;
   logic [8:0]        frac_inv;
   logic [16:0]       at_diff;
   logic [15:0]       ap4_in, ap4_ff;
   logic [15:0]       aq4_in, aq4_ff;
   logic [15:0]       at4_in, at4_ff;
   hsvrgb_sector_type sect4_ff;
   logic [7:0]        bri4_ff;

   // Stages 5 and 6: channel lanes
   hsvrgb_adv_type    lane_adv;
   hsvrgb_sector_type sect5_ff, sect6_ff;
   logic [7:0]        bri5_ff, bri6_ff;
   logic [7:0]        chp, chq, cht;

   // Stage 7: channel permutation
   logic [7:0] red7_in, red7_ff;
   logic [7:0] grn7_in, grn7_ff;
   logic [7:0] blu7_in, blu7_ff;

   // Ready chain: a stage loads when empty or when its successor loads
   always_comb begin
      rdy[NSTG] = !vld_ff[NSTG] || rsp_tready;
      for (int i = NSTG - 1; i >= 1; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i + 1];
      end
   end

   // Advance valid bits
   always_comb begin
      vld_in[1] = rdy[1] ? req_tvalid : vld_ff[1];
      for (int i = 2; i <= NSTG; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i - 1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1 datapath
   assign quo_prod = 21'(req_tdata[15:6]) * 21'(RECIP15_MUL);
   assign quo1_in  = quo_prod[20:14];

   // Stage 2 datapath
   assign quo_span = 17'(quo1_ff) * 17'(SECTOR_SPAN);
   assign rem_diff = {1'b0, hue1_ff} - quo_span;
   assign rem2_in  = rem_diff[9:0];
   assign q6_prod  = 13'(quo1_ff) * 13'(RECIP6_MUL);
   assign q6_2_in  = q6_prod[11:8];

   // Stage 3 datapath
   assign sect_diff = quo2_ff - 7'(q6_2_ff) * 7'(SECTOR_NUM);
   assign sect3_in  = hsvrgb_sector_type'(sect_diff[2:0]);
   assign frac_prod = 25'(rem2_ff) * 25'(FRAC_MUL);
   assign frac3_in  = frac_prod[23:16];

   // Stage 4 datapath
   assign frac_inv = 9'd256 - 9'(frac3_ff);
   assign subq     = 16'(frac3_ff) * 16'(sat3_ff);
   assign subt     = 17'(frac_inv) * 17'(sat3_ff);
   assign ap4_in   = FULL_SCALE - {sat3_ff, 8'h00};
   assign aq4_in   = FULL_SCALE - subq;
   assign at_diff  = 17'(FULL_SCALE) - subt;
   assign at4_in   = at_diff[15:0];

   // Pipeline payload registers
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         hue1_ff <= req_tdata[15:0];
         sat1_ff <= req_tdata[23:16];
         bri1_ff <= req_tdata[31:24];
         quo1_ff <= quo1_in;
      end
      if (rdy[2]) begin
         quo2_ff <= quo1_ff;
         rem2_ff <= rem2_in;
         q6_2_ff <= q6_2_in;
         sat2_ff <= sat1_ff;
         bri2_ff <= bri1_ff;
      end
      if (rdy[3]) begin
         sect3_ff <= sect3_in;
         frac3_ff <= frac3_in;
         sat3_ff  <= sat2_ff;
         bri3_ff  <= bri2_ff;
      end
      if (rdy[4]) begin
         ap4_ff   <= ap4_in;
         aq4_ff   <= aq4_in;
         at4_ff   <= at4_in;
         sect4_ff <= sect3_ff;
         bri4_ff  <= bri3_ff;
      end
      if (rdy[5]) begin
         sect5_ff <= sect4_ff;
         bri5_ff  <= bri4_ff;
      end
      if (rdy[6]) begin
         sect6_ff <= sect5_ff;
         bri6_ff  <= bri5_ff;
      end
      if (rdy[7]) begin
         red7_ff <= red7_in;
         grn7_ff <= grn7_in;
         blu7_ff <= blu7_in;
      end
   end

   // Scale p, q and t in parallel lanes
   assign lane_adv.load_mul = rdy[5];
   assign lane_adv.load_div = rdy[6];

   hsvrgb_lane u_lane_p (
      .clock  (clock),
      .adv    (lane_adv),
      .bright (bri4_ff),
      .scale  (ap4_ff),
      .chan   (chp)
   );

   hsvrgb_lane u_lane_q (
      .clock  (clock),
      .adv    (lane_adv),
      .bright (bri4_ff),
      .scale  (aq4_ff),
      .chan   (chq)
   );

   hsvrgb_lane u_lane_t (
      .clock  (clock),
      .adv    (lane_adv),
      .bright (bri4_ff),
      .scale  (at4_ff),
      .chan   (cht)
   );

   // Pick the channel order by sector
   always_comb begin
      case (sect6_ff)
         SECT_RED: begin
            red7_in = bri6_ff; grn7_in = cht;     blu7_in = chp;
         end
         SECT_YELLOW: begin
            red7_in = chq;     grn7_in = bri6_ff; blu7_in = chp;
         end
         SECT_GREEN: begin
            red7_in = chp;     grn7_in = bri6_ff; blu7_in = cht;
         end
         SECT_CYAN: begin
            red7_in = chp;     grn7_in = chq;     blu7_in = bri6_ff;
         end
         SECT_BLUE: begin
            red7_in = cht;     grn7_in = chp;     blu7_in = bri6_ff;
         end
         SECT_MAGENTA: begin
            red7_in = bri6_ff; grn7_in = chp;     blu7_in = chq;
         end
         default: begin
            red7_in = bri6_ff; grn7_in = bri6_ff; blu7_in = bri6_ff;
         end
      endcase
   end

   // Drive the result transaction
   assign req_tready = rdy[1];
   assign rsp_tvalid = vld_ff[NSTG];
   assign rsp_tdata  = {red7_ff, grn7_ff, blu7_ff, blu7_ff, grn7_ff, red7_ff};

   `HSVRGB_ASSERT_NOW(a_rem_range, clock, reset, vld_ff[2], rem2_ff < SECTOR_SPAN, "bad remainder")
   `HSVRGB_ASSERT_NOW(a_sect_range, clock, reset, vld_ff[2], sect_diff < 7'(SECTOR_NUM), "bad sect")
   `HSVRGB_ASSERT_NOW(a_ready_empty, clock, reset, !rsp_tvalid, req_tready, "stall while empty")
   `HSVRGB_ASSERT_NEXT(a_accept_load, clock, reset, req_tvalid && req_tready, vld_ff[1], "lost pixel")

endmodule
